// ----- rtl/core/mic_sample_gain_level_meter_defines.svh -----
// assertion macros for the microphone gain and level meter block
// included by the modules that carry concurrent checks, needs nothing else
`ifndef MIC_SAMPLE_GAIN_LEVEL_METER_DEFINES_SVH
`define MIC_SAMPLE_GAIN_LEVEL_METER_DEFINES_SVH
`ifndef SYNTHESIS
// implication checked at every edge outside reset
`define MSLM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define MSLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define MSLM_ASSERT(lbl, clk, rstn, prop, msg)
`define MSLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mslm_pkg.sv -----
// shared types and constants of the microphone gain and level meter
// used by every module of the block and by the bench, not by the channel interfaces; depends on nothing
package mslm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    // configuration port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;
    localparam int IDX_W  = 1;
    localparam int CFG_W  = 5;
    localparam logic [IDX_W-1:0] REG_SHIFT = 1'b0;
    localparam logic [IDX_W-1:0] REG_GAIN  = 1'b1;
    localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd11;
    localparam logic [CFG_W-1:0] GAIN_RESET  = 5'd4;

    // request opcodes of the input channel
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // sample limits
    localparam logic signed [15:0] FULL_POS = 16'sd32767;
    localparam logic signed [15:0] FULL_NEG = -16'sd32768;
    localparam logic [14:0] MAG_MAX = 15'h7fff;
    localparam logic [31:0] RMS_CAP = 32'd32768;

    // widths and iteration counts of the divide / square root unit
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SQUARE,
        ST_EMIT,
        ST_REPORT
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT,
        U_DONE
    } t_unit_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ----- rtl/core/mslm_chan_if.sv -----
// request channels of the level meter: sample input and result output
// payload widths follow the block's fields, no package needed
interface mslm_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] raw_sample;

    modport source (output valid, output op, output raw_sample, input ready);
    modport sink   (input valid, input op, input raw_sample, output ready);
endinterface

interface mslm_out_if;
    logic               valid;
    logic               ready;
    logic               is_report;
    logic signed [15:0] sample_out;
    logic        [14:0] raw_peak;
    logic        [14:0] gain_peak;
    logic        [15:0] rms_level;
    logic        [31:0] clip_total;

    modport source (output valid, output is_report, output sample_out, output raw_peak,
                    output gain_peak, output rms_level, output clip_total, input ready);
    modport sink   (input valid, input is_report, input sample_out, input raw_peak,
                    input gain_peak, input rms_level, input clip_total, output ready);
endinterface

// ----- rtl/core/mic_sample_gain_level_meter.sv -----
// top level of the microphone gain stage with peak / rms / clip level meter
// depends on mslm_pkg, mslm_chan_if, mslm_convert and mslm_divsqrt
//
//  channel   dir   fields                                            handshake
//  i_in      in    op, raw_sample                                    valid / ready
//  o_out     out   is_report, sample_out, raw_peak, gain_peak,       valid / ready
//                  rms_level, clip_total
//  apb       in    shift_amount @ 0x0, gain @ 0x4                    psel / penable
//
// a sample request steps the sequencer through the idle state it is taken in, convert,
//   square, then accumulate and emit; its result is registered in emit once the output is free
// a report request with samples counted waits on the shared subtractor:
//   64 divide steps and 32 square root steps; with no samples it skips the unit
// the output register frees the result side, the next request is taken once the
//   sequencer is back in idle; a stalled result holds the sequencer in its last state
// synchronous active-low reset clears statistics, configuration, the result valid flag and the sequencer
`include "mic_sample_gain_level_meter_defines.svh"
module mic_sample_gain_level_meter
    import mslm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mslm_in_if.sink           i_in,
    mslm_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // configuration
    logic [CFG_W-1:0] r_shift;
    logic [CFG_W-1:0] r_gain;
    logic             s_cfg_wr;
    logic [IDX_W-1:0] s_idx;

    // sequencer
    t_state r_state, n_state;
    logic   s_in_ready;
    logic   s_out_free;
    logic   s_emit_smp;
    logic   s_emit_rpt;
    logic   s_unit_start;
    logic   s_rpt_ready;

    // request and intermediate values
    logic signed [31:0] r_raw;
    logic signed [15:0] r_sample;
    logic        [14:0] r_raw_mag;
    logic        [14:0] r_gain_mag;
    logic               r_clip;
    logic        [31:0] r_sq;

    logic signed [15:0] s_sample;
    logic        [14:0] s_raw_mag;
    logic        [14:0] s_gain_mag;
    logic               s_clip;
    logic        [SUM_W:0] s_sum_add;

    // statistics
    logic [14:0]            r_raw_peak;
    logic [14:0]            r_gain_peak;
    logic [SUM_W-1:0]       r_sum;
    logic [COUNT_WIDTH-1:0] r_tally;
    logic [COUNT_WIDTH-1:0] r_clip_tally;

    // result register
    logic               r_out_valid;
    logic               r_is_report;
    logic signed [15:0] r_out_sample;
    logic        [14:0] r_out_raw_peak;
    logic        [14:0] r_out_gain_peak;
    logic        [15:0] r_out_rms;
    logic        [31:0] r_out_clip;

    t_unit_stat  s_unit_stat;
    logic [15:0] s_unit_rms;

    // apb access, writes land in the access phase
    assign pready   = 1'b1;
    assign s_idx    = paddr[ADDR_W-1:2];
    assign s_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (s_idx)
            REG_SHIFT: prdata = APB_DW'(r_shift);
            REG_GAIN:  prdata = APB_DW'(r_gain);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_gain  <= GAIN_RESET;
        end else if (s_cfg_wr) begin
            case (s_idx)
                REG_SHIFT: r_shift <= pwdata[CFG_W-1:0];
                REG_GAIN:  r_gain  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // shift, gain and saturation of the held raw word
    mslm_convert u_convert (
        .i_raw      (r_raw),
        .i_shift    (r_shift),
        .i_gain     (r_gain),
        .o_sample   (s_sample),
        .o_raw_mag  (s_raw_mag),
        .o_gain_mag (s_gain_mag),
        .o_clip     (s_clip)
    );

    // mean square and root for reports
    mslm_divsqrt #(
        .CW (COUNT_WIDTH)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_unit_start),
        .i_sum   (r_sum),
        .i_div   (r_tally),
        .o_stat  (s_unit_stat),
        .o_rms   (s_unit_rms)
    );

    assign s_out_free  = !r_out_valid || o_out.ready;
    assign s_rpt_ready = (r_tally == '0) || s_unit_stat.done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = (i_in.op == OP_REPORT) ? ST_REPORT : ST_CONV;
            ST_CONV:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_EMIT;
            ST_EMIT:   if (s_out_free) n_state = ST_IDLE;
            ST_REPORT: if (s_rpt_ready && s_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_in_ready   = (r_state == ST_IDLE);
        s_emit_smp   = (r_state == ST_EMIT) && s_out_free;
        s_emit_rpt   = (r_state == ST_REPORT) && s_rpt_ready && s_out_free;
        // no divide when nothing was counted, the report then carries zero rms
        s_unit_start = (r_state == ST_IDLE) && i_in.valid && (i_in.op == OP_REPORT)
                    && (r_tally != '0);
    end

    assign i_in.ready = s_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && s_in_ready) begin
            r_raw <= i_in.raw_sample;
        end
        if (r_state == ST_CONV) begin
            r_sample   <= s_sample;
            r_raw_mag  <= s_raw_mag;
            r_gain_mag <= s_gain_mag;
            r_clip     <= s_clip;
        end
        if (r_state == ST_SQUARE) begin
            // full 32-bit square of the signed sample
            r_sq <= $unsigned(32'(r_sample) * 32'(r_sample));
        end
    end

    assign s_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);

    // statistics: updated when the sample result is emitted, cleared by reset and by a report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_emit_rpt) begin
            r_raw_peak   <= '0;
            r_gain_peak  <= '0;
            r_sum        <= '0;
            r_tally      <= '0;
            r_clip_tally <= '0;
        end else if (s_emit_smp) begin
            if (r_raw_mag > r_raw_peak) begin
                r_raw_peak <= r_raw_mag;
            end
            if (r_gain_mag > r_gain_peak) begin
                r_gain_peak <= r_gain_mag;
            end
            // saturating accumulate
            r_sum <= s_sum_add[SUM_W] ? '1 : s_sum_add[SUM_W-1:0];
            if (r_tally != CNT_MAX) begin
                r_tally <= r_tally + 1'b1;
            end
            if (r_clip && (r_clip_tally != CNT_MAX)) begin
                r_clip_tally <= r_clip_tally + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_emit_smp || s_emit_rpt) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit_smp) begin
            r_is_report     <= 1'b0;
            r_out_sample    <= r_sample;
            r_out_raw_peak  <= '0;
            r_out_gain_peak <= '0;
            r_out_rms       <= '0;
            r_out_clip      <= '0;
        end else if (s_emit_rpt) begin
            r_is_report     <= 1'b1;
            r_out_sample    <= '0;
            r_out_raw_peak  <= r_raw_peak;
            r_out_gain_peak <= r_gain_peak;
            r_out_rms       <= (r_tally == '0) ? '0 : s_unit_rms;
            r_out_clip      <= 32'(r_clip_tally);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.is_report  = r_is_report;
    assign o_out.sample_out = r_out_sample;
    assign o_out.raw_peak   = r_out_raw_peak;
    assign o_out.gain_peak  = r_out_gain_peak;
    assign o_out.rms_level  = r_out_rms;
    assign o_out.clip_total = r_out_clip;

    `MSLM_ASSERT(a_clip_le_tally, i_clk, i_rst_n, r_clip_tally <= r_tally, "clip count above sample count")
    `MSLM_ASSERT(a_idle_unit_quiet, i_clk, i_rst_n, (r_state != ST_IDLE) || !s_unit_stat.busy, "root unit busy while idle")
    `MSLM_ASSERT_NEXT(a_report_clears, i_clk, i_rst_n, s_emit_rpt, (r_tally == '0) && (r_sum == '0) && r_out_valid && r_is_report, "report left statistics")
    `MSLM_ASSERT(a_report_waits, i_clk, i_rst_n, !s_emit_rpt || (r_tally == '0) || s_unit_stat.done, "report emitted before root done")

endmodule

// ----- rtl/core/mslm_convert.sv -----
// shift, gain and 16-bit saturation of one raw microphone word
// uses mslm_pkg for the full-scale limits
module mslm_convert
    import mslm_pkg::*;
(
    input  logic signed [31:0]      i_raw,
    input  logic        [CFG_W-1:0] i_shift,
    input  logic        [CFG_W-1:0] i_gain,
    output logic signed [15:0]      o_sample,
    output logic        [14:0]      o_raw_mag,
    output logic        [14:0]      o_gain_mag,
    output logic                    o_clip
);
    logic signed [31:0] s_shift;
    logic signed [31:0] s_neg;
    logic signed [37:0] s_prod;
    logic signed [15:0] s_gneg;

    assign s_shift = i_raw >>> i_shift;
    assign s_neg   = -s_shift;
    assign s_prod  = $signed({{6{s_shift[31]}}, s_shift}) * $signed({33'd0, i_gain});
    assign s_gneg  = -o_sample;

    // magnitude before gain, clamped
    always_comb begin
        if (s_shift > 32'sd32767 || s_shift < -32'sd32767) begin
            o_raw_mag = MAG_MAX;
        end else if (s_shift[31]) begin
            o_raw_mag = s_neg[14:0];
        end else begin
            o_raw_mag = s_shift[14:0];
        end
    end

    always_comb begin
        if (s_prod > 38'(FULL_POS)) begin
            o_sample = FULL_POS;
        end else if (s_prod < 38'(FULL_NEG)) begin
            o_sample = FULL_NEG;
        end else begin
            o_sample = s_prod[15:0];
        end
    end

    // negative full scale reads as the positive limit
    always_comb begin
        if (o_sample == FULL_NEG) begin
            o_gain_mag = MAG_MAX;
        end else if (o_sample[15]) begin
            o_gain_mag = s_gneg[14:0];
        end else begin
            o_gain_mag = o_sample[14:0];
        end
    end

    assign o_clip = (o_sample == FULL_POS) || (o_sample == FULL_NEG);

endmodule

// ----- rtl/core/mslm_divsqrt.sv -----
// iterative unit: restoring divide of the square sum by the count, then
// digit-by-digit square root, both on one shared subtractor; uses mslm_pkg
`include "mic_sample_gain_level_meter_defines.svh"
module mslm_divsqrt
    import mslm_pkg::*;
#(
    parameter int CW = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [CW-1:0]    i_div,
    output t_unit_stat       o_stat,
    output logic [15:0]      o_rms
);
    localparam int SUB_W = (CW + 1 > ROOT_W + 3) ? CW + 1 : ROOT_W + 3;
    localparam int CNT_W = $clog2(DIV_STEPS);

    t_unit_state        r_state, n_state;
    logic [SUM_W-1:0]   r_work;
    logic [SUB_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CW-1:0]      r_div;
    logic [CNT_W-1:0]   r_cnt;

    logic [SUB_W-1:0]   s_a;
    logic [SUB_W-1:0]   s_b;
    logic [SUB_W:0]     s_diff;
    logic               s_ge;
    logic               s_last;

    // shared compare / subtract
    always_comb begin
        if (r_state == U_SQRT) begin
            s_a = SUB_W'({r_rem[ROOT_W:0], r_work[SUM_W-1 -: 2]});
            s_b = SUB_W'({r_root, 2'b01});
        end else begin
            s_a = SUB_W'({r_rem[CW-1:0], r_work[SUM_W-1]});
            s_b = SUB_W'(r_div);
        end
    end
    assign s_diff = {1'b0, s_a} - {1'b0, s_b};
    assign s_ge   = !s_diff[SUB_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: if (i_start) n_state = U_DIV;
            U_DIV: if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = U_SQRT;
            U_SQRT: if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = U_DONE;
            U_DONE: if (i_start) n_state = U_DIV;
            default: n_state = U_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state == U_DIV) || (r_state == U_SQRT);
        o_stat.done = (r_state == U_DONE);
        s_last      = (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_start || s_last) begin
                r_cnt <= '0;
            end else if (o_stat.busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_sum;
            r_rem  <= '0;
            r_div  <= i_div;
            r_root <= '0;
        end else begin
            case (r_state)
                U_DIV: begin
                    // quotient bits shift in where dividend bits leave
                    r_work <= {r_work[SUM_W-2:0], s_ge};
                    r_rem  <= (r_cnt == CNT_W'(DIV_STEPS - 1)) ? '0
                            : (s_ge ? s_diff[SUB_W-1:0] : s_a);
                end
                U_SQRT: begin
                    r_work <= {r_work[SUM_W-3:0], 2'b00};
                    r_rem  <= s_ge ? s_diff[SUB_W-1:0] : s_a;
                    r_root <= {r_root[ROOT_W-2:0], s_ge};
                end
                default: ;
            endcase
        end
    end

    assign o_rms = (r_root > RMS_CAP) ? 16'h8000 : r_root[15:0];

    `MSLM_ASSERT(a_div_rem, i_clk, i_rst_n, (r_state != U_DIV) || (r_rem < SUB_W'(r_div)), "divide remainder not below divisor")
    `MSLM_ASSERT(a_sqrt_rem, i_clk, i_rst_n, (r_state != U_SQRT) || (r_rem <= SUB_W'({r_root, 1'b0})), "root remainder too large")
    `MSLM_ASSERT_NEXT(a_div_to_sqrt, i_clk, i_rst_n, (r_state == U_DIV) && (r_cnt == CNT_W'(DIV_STEPS - 1)) && !i_start, (r_state == U_SQRT) && (r_rem == '0), "root phase entered without clear")

endmodule

// ----- sim/mic_sample_gain_level_meter_tb.sv -----
// self-checking bench for the microphone gain stage and level meter
// drives sample / report requests and apb register writes, predicts every result
// depends on mslm_pkg, mslm_chan_if and the mic_sample_gain_level_meter rtl
`timescale 1ns / 100ps
module mic_sample_gain_level_meter_tb;
    import mslm_pkg::*;

    // one pending request, drain_first makes the sender wait for all results
    typedef struct {
        logic               op;
        logic signed [31:0] raw;
        logic               drain_first;
    } t_mic_req;

    // one result as the output channel carries it
    typedef struct packed {
        logic               is_report;
        logic signed [15:0] sample_out;
        logic        [14:0] raw_peak;
        logic        [14:0] gain_peak;
        logic        [15:0] rms_level;
        logic        [31:0] clip_total;
    } t_meter_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // apb side, idle from time zero
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mslm_in_if  in_if ();
    mslm_out_if out_if ();

    mic_sample_gain_level_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: register mirror and statistics
    logic [4:0]  shift_cfg = SHIFT_RESET;
    logic [4:0]  gain_cfg  = GAIN_RESET;
    logic [14:0] raw_peak_hold  = '0;
    logic [14:0] gain_peak_hold = '0;
    logic [63:0] square_sum     = '0;
    logic [31:0] sample_tally   = '0;
    logic [31:0] clip_tally     = '0;

    t_mic_req   mic_requests[$];      // filled by the stimulus, drained by the driver
    t_meter_res meter_results_due[$]; // predicted results in arrival order
    t_mic_req   cur_req;

    int  reqs_queued = 0;
    int  reqs_accepted = 0;
    int  samples_sent = 0;
    int  reports_sent = 0;
    int  settings_used = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    bit  idling_on = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;

    // floor square root by setting one result bit at a time
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    // works out the result of one accepted request and updates the statistics
    function automatic void predict_meter_result(input t_mic_req req);
        t_meter_res         res;
        logic signed [31:0] shifted;
        longint             scaled;
        longint             mag;
        logic [63:0]        sq;
        logic [63:0]        root;
        res = '0;
        if (req.op == OP_REPORT) begin
            // mean square and its root, nothing counted gives zero
            root = '0;
            if (sample_tally != 0) begin
                root = floor_sqrt(square_sum / 64'(sample_tally));
                if (root > 64'(RMS_CAP)) begin
                    root = 64'(RMS_CAP);
                end
            end
            res.is_report  = 1'b1;
            res.raw_peak   = raw_peak_hold;
            res.gain_peak  = gain_peak_hold;
            res.rms_level  = root[15:0];
            res.clip_total = clip_tally;
            raw_peak_hold  = '0;
            gain_peak_hold = '0;
            square_sum     = '0;
            sample_tally   = '0;
            clip_tally     = '0;
        end else begin
            shifted = req.raw >>> shift_cfg;
            // magnitude before gain, full scale held as 32767
            mag = (shifted < 0) ? -longint'(shifted) : longint'(shifted);
            if (mag > 32767) begin
                mag = 32767;
            end
            if (mag > longint'(raw_peak_hold)) begin
                raw_peak_hold = mag[14:0];
            end
            scaled = longint'(shifted) * longint'(gain_cfg);
            if (scaled > 32767) begin
                scaled = 32767;
            end else if (scaled < -32768) begin
                scaled = -32768;
            end
            mag = (scaled < 0) ? -scaled : scaled;
            if (mag > 32767) begin
                mag = 32767;
            end
            if (mag > longint'(gain_peak_hold)) begin
                gain_peak_hold = mag[14:0];
            end
            // saturating accumulators
            sq = 64'(scaled * scaled);
            if (square_sum > ~64'd0 - sq) begin
                square_sum = ~64'd0;
            end else begin
                square_sum = square_sum + sq;
            end
            if (sample_tally != '1) begin
                sample_tally++;
            end
            if ((scaled == 32767 || scaled == -32768) && clip_tally != '1) begin
                clip_tally++;
            end
            res.sample_out = scaled[15:0];
        end
        meter_results_due.push_back(res);
    endfunction

    // compares one delivered result with the oldest prediction
    function automatic void check_meter_result(input t_meter_res got);
        t_meter_res want;
        results_checked++;
        if (meter_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected result: rep=%0d smp=%0d rawpk=%0d gainpk=%0d rms=%0d clip=%0d",
                         got.is_report, got.sample_out, got.raw_peak, got.gain_peak,
                         got.rms_level, got.clip_total);
            end
            return;
        end
        want = meter_results_due.pop_front();
        if (got.is_report !== want.is_report || got.sample_out !== want.sample_out ||
            got.raw_peak !== want.raw_peak || got.gain_peak !== want.gain_peak ||
            got.rms_level !== want.rms_level || got.clip_total !== want.clip_total) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch at %0t: expected rep=%0d smp=%0d rawpk=%0d gainpk=%0d rms=%0d clip=%0d",
                         $realtime, want.is_report, want.sample_out, want.raw_peak,
                         want.gain_peak, want.rms_level, want.clip_total);
                $display("    got rep=%0d smp=%0d rawpk=%0d gainpk=%0d rms=%0d clip=%0d",
                         got.is_report, got.sample_out, got.raw_peak, got.gain_peak,
                         got.rms_level, got.clip_total);
            end
        end
    endfunction

    // driver: presents queued requests, predicts each one as it is accepted
    always @(posedge i_clk) begin : drive_requests
        logic present;
        present = 1'b0;
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.op         <= OP_SAMPLE;
            in_if.raw_sample <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_meter_result(cur_req);
                reqs_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (idling_on && $urandom_range(0, 5) == 0) begin
                    // starts an idle burst whose length is drawn at random
                    send_gap = $urandom_range(0, 4);
                end else if (mic_requests.size() != 0 &&
                             !(mic_requests[0].drain_first && meter_results_due.size() != 0)) begin
                    cur_req = mic_requests.pop_front();
                    present = 1'b1;
                    if (cur_req.op == OP_REPORT) begin
                        reports_sent++;
                    end else begin
                        samples_sent++;
                    end
                end
                in_if.valid <= present;
                if (present) begin
                    in_if.op         <= cur_req.op;
                    in_if.raw_sample <= cur_req.raw;
                end
            end
        end
    end

    // monitor: random result stalls, checks every accepted result
    always @(posedge i_clk) begin : collect_results
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_meter_result({out_if.is_report, out_if.sample_out, out_if.raw_peak,
                                    out_if.gain_peak, out_if.rms_level, out_if.clip_total});
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // queues one request for the driver
    task automatic push_request(input logic op, input logic [31:0] raw, input logic drain);
        t_mic_req req;
        req.op = op;
        req.raw = raw;
        req.drain_first = drain;
        mic_requests.push_back(req);
        reqs_queued++;
    endtask

    // waits until every request is taken and every result is back
    task automatic wait_idle();
        while (reqs_accepted != reqs_queued || meter_results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // apb write: setup then access, upper data bits sometimes carry noise
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [4:0] value);
        logic [31:0] data;
        data = {27'd0, value};
        if ($urandom_range(0, 1) == 1) begin
            data = ($urandom() & ~32'h1f) | data;
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SHIFT) begin
            shift_cfg = value;
        end else begin
            gain_cfg = value;
        end
    endtask

    // new shift and gain, only called with the block idle
    task automatic set_levels(input logic [4:0] shift, input logic [4:0] gain);
        wait_idle();
        reg_write(REG_SHIFT, shift);
        reg_write(REG_GAIN, gain);
        settings_used++;
    endtask

    // raw word: full random, rail values, or an amplitude that survives the shift
    function automatic logic [31:0] pick_raw();
        int                 sel;
        int                 k;
        logic signed [31:0] amp;
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
            return $urandom();
        end
        if (sel == 5) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        k = $urandom_range(0, 15);
        amp = int'($urandom_range(0, 2 ** (k + 1))) - (1 << k);
        return (amp <<< shift_cfg) | ($urandom() & ((32'd1 << shift_cfg) - 1));
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: report with nothing counted, then rails and zero
        push_request(OP_REPORT, 32'd0, 1'b0);
        push_request(OP_SAMPLE, 32'h0000_0000, 1'b0);
        push_request(OP_SAMPLE, 32'hffff_ffff, 1'b0);
        push_request(OP_SAMPLE, 32'h7fff_ffff, 1'b0);
        push_request(OP_SAMPLE, 32'h8000_0000, 1'b0);
        push_request(OP_SAMPLE, 32'h0001_2345, 1'b0);
        push_request(OP_REPORT, 32'hffff_ffff, 1'b0);

        // no shift, unity gain: magnitude 32768 held as 32767
        set_levels(5'd0, 5'd1);
        push_request(OP_SAMPLE, -32'sd32768, 1'b0);
        push_request(OP_SAMPLE, 32'sd32767, 1'b0);
        push_request(OP_SAMPLE, 32'h8000_0000, 1'b0);
        push_request(OP_REPORT, 32'd0, 1'b0);

        // gain of 16: both rails clip
        set_levels(5'd0, 5'd16);
        push_request(OP_SAMPLE, 32'sd1, 1'b0);
        push_request(OP_SAMPLE, -32'sd2048, 1'b0);
        push_request(OP_SAMPLE, 32'sd2048, 1'b0);
        push_request(OP_REPORT, 32'd0, 1'b0);

        // zero gain gives silence
        set_levels(5'd5, 5'd0);
        push_request(OP_SAMPLE, $urandom(), 1'b0);
        push_request(OP_SAMPLE, -32'sd1000, 1'b0);
        push_request(OP_REPORT, 32'd0, 1'b0);

        // widest shift with a gain above the usual range
        set_levels(5'd31, 5'd31);
        push_request(OP_SAMPLE, 32'h8000_0000, 1'b0);
        push_request(OP_SAMPLE, 32'h7fff_ffff, 1'b0);
        push_request(OP_SAMPLE, 32'hffff_ffff, 1'b0);
        push_request(OP_REPORT, 32'd0, 1'b0);

        // random phases, each with its own settings
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       set_levels(5'd0, 5'd1);
                1:       set_levels(5'd31, 5'd16);
                2:       set_levels(5'd16, 5'd16);
                3:       set_levels(5'($urandom_range(0, 31)), 5'($urandom_range(17, 31)));
                default: set_levels(5'($urandom_range(0, 31)), 5'($urandom_range(1, 16)));
            endcase
            // idle bursts on most phases, none at the end of the run
            idling_on = (p % 4 != 3) && (p != 11);
            for (int n = 0; n < 145; n++) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_request(OP_REPORT, $urandom(), $urandom_range(0, 79) == 0);
                end else begin
                    push_request(OP_SAMPLE, pick_raw(),
                                 (p == 0 && n == 70) || $urandom_range(0, 79) == 0);
                end
            end
        end

        wait_idle();
        idling_on = 1'b0;
        // room for a late or spurious result, report path is the slow one
        repeat (150) @(posedge i_clk);

        $display("covered %0d samples and %0d reports over %0d register settings",
                 samples_sent, reports_sent, settings_used);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && meter_results_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard, far above the slowest correct run
    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", meter_results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
